>>> hw/rtl/arti_pkg.sv
// Shared types and constants for the ASCII radix-to-integer parser.
// Used by the front classifier, the item queue, the parsing back end and the top level.
// No dependencies.
package arti_pkg;

	// Character codes the parser reacts to.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	// Subtracted from a letter to get its digit value.
	localparam logic [7:0] UPPER_OFFSET = 8'd55;
	localparam logic [7:0] LOWER_OFFSET = 8'd87;

	localparam int          RADIX_BITS  = 6;
	localparam logic [5:0]  RADIX_RESET = 6'd10;
	localparam logic [5:0]  RADIX_HEX   = 6'd16;

	// Configuration register map (word index taken from paddr[2]).
	localparam int          ADDR_BITS = 3;
	localparam logic [0:0]  REG_RADIX = 1'b0;

	// One classified character as it travels from the front end to the back end.
	typedef struct packed {
		logic       is_digit;   // 0-9, A-Z or a-z
		logic [5:0] dval;       // digit value 0..35, valid with is_digit
		logic       is_space;
		logic       is_minus;
		logic       is_plus;
		logic       is_x;       // 'x' or 'X'
		logic       is_zero;    // exactly '0'
		logic       last;       // last character of the field
		logic [5:0] radix;      // base in force when the character was accepted
	} arti_item_t;

endpackage

>>> hw/rtl/arti_front.sv
// Front end of the parser: takes characters off the input stream and classifies them.
// Depends on arti_pkg for character codes and the item type.
module arti_front
	import arti_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] text_char
	input  logic        s_tlast,    // field_end
	input  logic [5:0]  radix,
	input  logic        q_full,
	output logic        q_push,
	output arti_item_t  q_item
);

	logic [7:0] ch;
	logic [7:0] dval_wide;
	logic       is_digit;

	assign ch = s_tdata;

	always_comb begin
		is_digit  = 1'b1;
		dval_wide = 8'd0;
		if (ch inside {[CH_ZERO:CH_NINE]}) begin
			dval_wide = ch - CH_ZERO;
		end else if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
			dval_wide = ch - UPPER_OFFSET;
		end else if (ch inside {[CH_LO_A:CH_LO_Z]}) begin
			dval_wide = ch - LOWER_OFFSET;
		end else begin
			is_digit = 1'b0;
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.is_digit = is_digit;
		q_item.dval     = dval_wide[5:0];
		q_item.is_space = (ch == CH_SPACE);
		q_item.is_minus = (ch == CH_MINUS);
		q_item.is_plus  = (ch == CH_PLUS);
		q_item.is_x     = (ch == CH_UP_X) || (ch == CH_LO_X);
		q_item.is_zero  = (ch == CH_ZERO);
		q_item.last     = s_tlast;
		q_item.radix    = radix;
	end

endmodule

>>> hw/rtl/arti_queue.sv
// Two-entry queue of classified characters between the front end and the back end.
// Depends on arti_pkg for the item type.
module arti_queue
	import arti_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  arti_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output arti_item_t head_item
);

	arti_item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q[1];
	assign head_valid = (count_q != 2'd0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/arti_back.sv
// Back end of the parser: runs the parse state machine and the signed multiply-add
// accumulator, and holds the result in an output register. Depends on arti_pkg.
module arti_back
	import arti_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  arti_item_t  head_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // [31:0] parsed_value, [47:32] chars_used
	output logic        m_tuser     // whole_field_used
);

	localparam logic [2:0] PH_SPACE  = 3'd0;
	localparam logic [2:0] PH_PREFIX = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_DIGITS = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam int VEXT_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;
	localparam int CEXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [2:0]            phase_q, phase_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic                  neg_q, neg_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;

	logic                  out_valid_q;
	logic [31:0]           out_value_q;
	logic [15:0]           out_count_q;
	logic                  out_whole_q;

	logic                  out_free;
	logic                  digit_ok;
	logic                  first_char;
	logic [1:0]            inc;
	logic [VALUE_BITS-1:0] prod;
	logic [VALUE_BITS-1:0] dval_ext;
	logic [VALUE_BITS-1:0] mac;
	logic [COUNT_BITS:0]   cnt_sum;
	logic [VEXT_BITS-1:0]  value_ext;
	logic [CEXT_BITS-1:0]  count_ext;

	assign out_free = !out_valid_q || m_tready;
	assign pop      = head_valid && (!head_item.last || out_free);

	assign digit_ok = head_item.is_digit && (head_item.dval < head_item.radix);

	// The accumulator already carries the sign, so a negative field subtracts each digit.
	assign prod     = acc_q * VALUE_BITS'(head_item.radix);
	assign dval_ext = VALUE_BITS'(head_item.dval);
	assign mac      = neg_q ? (prod - dval_ext) : (prod + dval_ext);

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		inc        = 2'd0;
		first_char = 1'b0;
		case (phase_q)
			PH_SPACE: begin
				if (head_item.is_space) begin
					inc = 2'd1;
				end else if (head_item.is_minus) begin
					neg_d   = 1'b1;
					inc     = 2'd1;
					phase_d = PH_PREFIX;
				end else if (head_item.is_plus) begin
					inc     = 2'd1;
					phase_d = PH_PREFIX;
				end else begin
					first_char = 1'b1;
				end
			end
			PH_PREFIX: begin
				first_char = 1'b1;
			end
			PH_ZERO: begin
				// A held-back '0' is either half of a hex prefix or a leading digit.
				if (head_item.is_x) begin
					inc     = 2'd2;
					phase_d = PH_DIGITS;
				end else if (head_item.radix == 6'd0) begin
					phase_d = PH_DONE;
				end else if (digit_ok) begin
					acc_d   = mac;
					inc     = 2'd2;
					phase_d = PH_DIGITS;
				end else begin
					inc     = 2'd1;
					phase_d = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (digit_ok) begin
					acc_d = mac;
					inc   = 2'd1;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		if (first_char) begin
			if ((head_item.radix == RADIX_HEX) && head_item.is_zero && !head_item.last) begin
				phase_d = PH_ZERO;
			end else if (digit_ok) begin
				acc_d   = mac;
				inc     = 2'd1;
				phase_d = PH_DIGITS;
			end else begin
				phase_d = PH_DONE;
			end
		end
	end

	assign cnt_sum = {1'b0, cnt_q} + (COUNT_BITS+1)'(inc);
	assign cnt_d   = cnt_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : cnt_sum[COUNT_BITS-1:0];

	assign value_ext = VEXT_BITS'($signed(acc_d));
	assign count_ext = CEXT_BITS'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SPACE;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_item.last) begin
					phase_q <= PH_SPACE;
					acc_q   <= '0;
					neg_q   <= 1'b0;
					cnt_q   <= '0;
				end else begin
					phase_q <= phase_d;
					acc_q   <= acc_d;
					neg_q   <= neg_d;
					cnt_q   <= cnt_d;
				end
			end
			if (pop && head_item.last) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.last) begin
			out_value_q <= value_ext[31:0];
			out_count_q <= count_ext[15:0];
			out_whole_q <= (phase_d != PH_DONE);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_value_q};
	assign m_tuser  = out_whole_q;

endmodule

>>> hw/rtl/ascii_radix_to_integer_top.sv
// Top level of the ASCII radix-to-integer parser: APB radix register, stream ports,
// and the front end, queue and back end. Depends on arti_pkg, arti_front, arti_queue, arti_back.
//
// This block parses one text field, one character per stream request, into a signed
// integer in the base held in the radix register (reset 10). It skips leading spaces,
// takes an optional '+' or '-', skips a "0x"/"0X" prefix when the base is 16, and then
// accumulates digits 0-9, A-Z, a-z until a character is not a digit below the base; the
// rest of the field is ignored. The character sent with s_tlast high closes the field and
// produces exactly one result: the value (wrapping at VALUE_BITS and sign-extended to 32
// bits), the count of characters consumed (saturating at 2^COUNT_BITS - 1) and, on
// m_tuser, a flag that is 1 when no character stopped the parse. The block takes one
// character per clock cycle unless a field's last character waits for the output register;
// that rate is set by the back end's accumulator, which does one multiply by the 6-bit
// base and one add or subtract per cycle. A field's last character is registered in the
// queue and then in the output register before its result shows on m_tvalid. A two-request
// queue sits between the classifying front end and the parsing back end, and the result sits in
// an output register, so characters keep flowing while a finished result waits on m_tready.
// The base travels with each character, so a register write between fields, or between
// characters of a field, applies from the next character accepted. Register writes are
// expected only while the block is idle between requests.
module ascii_radix_to_integer_top
	import arti_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// Input stream: one character per request
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] text_char
	input  logic                 s_tlast,   // field_end
	// Output stream: one result per field
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata,   // [31:0] parsed_value, [47:32] chars_used
	output logic                 m_tuser    // whole_field_used
);

	logic [RADIX_BITS-1:0] radix_q;
	logic                  reg_hit;

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_valid;
	arti_item_t q_in_item;
	arti_item_t q_head_item;

	// The register file has a single word; paddr[2] selects it and the byte offset is ignored.
	assign reg_hit = (paddr[2] == REG_RADIX);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? 32'(radix_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			radix_q <= pwdata[RADIX_BITS-1:0];
		end
	end

	arti_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.radix    (radix_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in_item)
	);

	arti_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_head_item)
	);

	arti_back #(
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_item  (q_head_item),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
